>>> rtl/c_subset_lexer_core_macros.svh
// Assertion macros for the lexer core checker.
`ifndef C_SUBSET_LEXER_CORE_MACROS_SVH
`define C_SUBSET_LEXER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CSL_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication.
`define CSL_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

>>> rtl/csl_pkg.sv
// Shared types and constants for the C subset lexer.
`default_nettype none
package csl_pkg;
    localparam logic [5:0] KD_IDENT  = 6'd14;
    localparam logic [5:0] KD_NUMBER = 6'd15;
    localparam logic [5:0] KD_ERROR  = 6'd16;
    localparam logic [5:0] KD_STRING = 6'd17;
    localparam logic [5:0] KD_CHAR   = 6'd18;
    localparam logic [5:0] KD_EOF    = 6'd19;
    localparam logic [19:0] LINE_MAX = 20'hFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [30:0] HEX_MAX  = 31'h7FFFFFFF;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_ZERO, M_DEC, M_HEX, M_STR, M_STR_ESC, M_CHR_OPEN,
        M_CHR_ESC, M_CHR_CLOSE, M_OPER, M_LINE_SKIP, M_BLOCK, M_BLOCK_STAR
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] line;
        logic [15:0] column;
        logic [23:0] offset;
        logic [23:0] length;
        logic [30:0] value;
        logic        last;
    } token_t;

    // request queued between front and back: one input byte with its flag
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } byte_req_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5F;
    endfunction
    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h0;
        if (is_digit(c)) t = c - 8'h30;
        else if (c >= 8'h61) t = c - 8'h57;
        else t = c - 8'h37;
        return t[3:0];
    endfunction
    function automatic logic [5:0] lone_kind(input logic [7:0] p);
        logic [5:0] k;
        case (p)
            "+": k = 6'd22; "-": k = 6'd26; "*": k = 6'd28; "/": k = 6'd30;
            "=": k = 6'd32; "!": k = 6'd34; "<": k = 6'd37; ">": k = 6'd40;
            "&": k = 6'd42; "|": k = 6'd44;
            default: k = KD_ERROR;
        endcase
        return k;
    endfunction
    // returns {formed, kind}
    function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (p)
            "+": if (c == "+") r = {1'b1, 6'd20}; else if (c == "=") r = {1'b1, 6'd21};
            "-": if (c == "-") r = {1'b1, 6'd23}; else if (c == "=") r = {1'b1, 6'd24};
                 else if (c == ">") r = {1'b1, 6'd25};
            "*": if (c == "=") r = {1'b1, 6'd27};
            "/": if (c == "=") r = {1'b1, 6'd29};
            "=": if (c == "=") r = {1'b1, 6'd31};
            "!": if (c == "=") r = {1'b1, 6'd33};
            "<": if (c == "=") r = {1'b1, 6'd35}; else if (c == "<") r = {1'b1, 6'd36};
            ">": if (c == "=") r = {1'b1, 6'd38}; else if (c == ">") r = {1'b1, 6'd39};
            "&": if (c == "&") r = {1'b1, 6'd41};
            "|": if (c == "|") r = {1'b1, 6'd43};
            default: r = 7'd0;
        endcase
        return r;
    endfunction
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "(": k = 6'd45; ")": k = 6'd46; "{": k = 6'd47; "}": k = 6'd48;
            "[": k = 6'd49; "]": k = 6'd50; ";": k = 6'd51; ",": k = 6'd52;
            ".": k = 6'd53; ":": k = 6'd54; "?": k = 6'd55; "%": k = 6'd56;
            "^": k = 6'd57; "~": k = 6'd58;
            default: k = KD_ERROR;
        endcase
        return k;
    endfunction
    // keyword lookup on a packed 16-byte word, byte 0 in the low bits
    function automatic logic [5:0] kw_kind(input logic [127:0] w, input logic [4:0] n);
        logic [5:0] k;
        k = KD_IDENT;
        case (n)
            5'd2: if (w[15:0] == "fi") k = 6'd6;
            5'd3: if (w[23:0] == "tni") k = 6'd0; else if (w[23:0] == "rof") k = 6'd9;
            5'd4: if (w[31:0] == "rahc") k = 6'd1; else if (w[31:0] == "diov") k = 6'd2;
                  else if (w[31:0] == "mune") k = 6'd5; else if (w[31:0] == "esle") k = 6'd7;
            5'd5: if (w[39:0] == "elihw") k = 6'd8; else if (w[39:0] == "kaerb") k = 6'd12;
            5'd6: if (w[47:0] == "tcurts") k = 6'd3; else if (w[47:0] == "nruter") k = 6'd10;
                  else if (w[47:0] == "foezis") k = 6'd11;
            5'd7: if (w[55:0] == "fedepyt") k = 6'd4;
            5'd8: if (w[63:0] == "eunitnoc") k = 6'd13;
            default: k = KD_IDENT;
        endcase
        return k;
    endfunction
endpackage
`default_nettype wire

>>> rtl/csl_front.sv
// Front end: input request capture into a short queue.
`default_nettype none
module csl_front #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire csl_pkg::byte_req_t in_req,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output csl_pkg::byte_req_t     q_req
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    csl_pkg::byte_req_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push;

    assign in_ready = cnt_reg != (AW+1)'(DEPTH);
    assign push     = in_valid && in_ready;
    assign q_valid  = cnt_reg != '0;
    assign q_req    = mem_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (push) mem_reg[wp_reg] <= in_req;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (q_pop) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/csl_back.sv
// Back end: lexer mode update, token building and two-entry output buffer.
`default_nettype none
module csl_back #(
    parameter int KEYWORD_CHARS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire csl_pkg::byte_req_t q_req,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output csl_pkg::token_t         out_tok
);
    localparam int WB = 8 * KEYWORD_CHARS;
    localparam int CW = $clog2(KEYWORD_CHARS);

    csl_pkg::mode_t mode_reg, mode_next;
    logic [23:0] pos_reg, pos_next, spos_reg, spos_next;
    logic [19:0] line_reg, line_next, sline_reg, sline_next;
    logic [15:0] col_reg, col_next, scol_reg, scol_next;
    logic [WB-1:0] word_reg, word_next;
    logic [4:0] wcnt_reg, wcnt_next;
    logic [30:0] hex_reg, hex_next;
    logic [7:0] pend_reg, pend_next;

    // output buffer, two slots, FIFO order
    csl_pkg::token_t ob_reg [2];
    logic [1:0] ocnt_reg;
    logic       orp_reg, owp_reg;

    csl_pkg::token_t t0, t1;
    logic n_out;
    logic two_out;
    logic [7:0] c;

    assign c = q_req.ch;
    assign q_pop = q_valid && (ocnt_reg == 2'd0 || (ocnt_reg == 2'd1 && out_ready));
    assign out_valid = ocnt_reg != 2'd0;
    assign out_tok = ob_reg[orp_reg];

    always_comb
    begin
        logic [23:0] span, bpos;
        logic [19:0] bline;
        logic [15:0] bcol;
        logic used, has1;
        logic [6:0] pk;
        logic [127:0] w;
        csl_pkg::token_t tk;
        mode_next = mode_reg; pos_next = pos_reg; line_next = line_reg; col_next = col_reg;
        spos_next = spos_reg; sline_next = sline_reg; scol_next = scol_reg;
        word_next = word_reg; wcnt_next = wcnt_reg; hex_next = hex_reg; pend_next = pend_reg;
        t0 = '0; t1 = '0; has1 = 1'b0; n_out = 1'b0; two_out = 1'b0; used = 1'b1;
        bpos = '0; bline = '0; bcol = '0;
        span = pos_reg - spos_reg;
        w = '0; w[WB-1:0] = word_reg;
        tk = '0; tk.line = sline_reg; tk.column = scol_reg; tk.offset = spos_reg;
        tk.length = span;
        pk = csl_pkg::pair_kind(pend_reg, c);
        // pending-token handling (first token)
        case (mode_reg)
            csl_pkg::M_IDENT:
                if (q_req.eos || !csl_pkg::is_word(c))
                begin
                    tk.kind = (wcnt_reg > 5'(KEYWORD_CHARS)) ? csl_pkg::KD_IDENT
                              : csl_pkg::kw_kind(w, wcnt_reg);
                    has1 = 1'b1; used = 1'b0;
                end
                else
                begin
                    if (wcnt_reg < 5'(KEYWORD_CHARS)) word_next[8*wcnt_reg[CW-1:0] +: 8] = c;
                    if (wcnt_reg < 5'd31) wcnt_next = wcnt_reg + 5'd1;
                end
            csl_pkg::M_ZERO:
                if (!q_req.eos && (c == "x" || c == "X")) mode_next = csl_pkg::M_HEX;
                else if (!q_req.eos && csl_pkg::is_digit(c)) mode_next = csl_pkg::M_DEC;
                else begin tk.kind = csl_pkg::KD_NUMBER; has1 = 1'b1; used = 1'b0; end
            csl_pkg::M_DEC:
                if (q_req.eos || !csl_pkg::is_digit(c))
                begin
                    tk.kind = csl_pkg::KD_NUMBER; has1 = 1'b1; used = 1'b0;
                end
            csl_pkg::M_HEX:
                if (q_req.eos || !csl_pkg::is_hex(c))
                begin
                    tk.kind = csl_pkg::KD_NUMBER; tk.value = hex_reg; has1 = 1'b1; used = 1'b0;
                end
                else if (hex_reg <= (csl_pkg::HEX_MAX >> 4))
                    hex_next = {hex_reg[26:0], csl_pkg::hex_val(c)};
                else hex_next = csl_pkg::HEX_MAX;
            csl_pkg::M_STR:
                if (q_req.eos || c == 8'h0A)
                begin
                    tk.kind = csl_pkg::KD_ERROR; has1 = 1'b1; used = 1'b0;
                end
                else if (c == 8'h22)
                begin
                    tk.kind = csl_pkg::KD_STRING; has1 = 1'b1; mode_next = csl_pkg::M_IDLE;
                end
                else if (c == 8'h5C) mode_next = csl_pkg::M_STR_ESC;
            csl_pkg::M_STR_ESC:
                if (q_req.eos)
                begin
                    tk.kind = csl_pkg::KD_ERROR; has1 = 1'b1; used = 1'b0;
                end
                else mode_next = csl_pkg::M_STR;
            csl_pkg::M_CHR_OPEN:
                if (q_req.eos || c == 8'h0A)
                begin
                    tk.kind = csl_pkg::KD_ERROR; has1 = 1'b1; used = 1'b0;
                    if (!q_req.eos) tk.length = '0;
                end
                else if (c == 8'h5C) mode_next = csl_pkg::M_CHR_ESC;
                else if (c == 8'h27)
                begin
                    tk.kind = csl_pkg::KD_CHAR; tk.length = '0; has1 = 1'b1;
                    mode_next = csl_pkg::M_IDLE;
                end
                else mode_next = csl_pkg::M_CHR_CLOSE;
            csl_pkg::M_CHR_ESC:
                if (q_req.eos)
                begin
                    tk.kind = csl_pkg::KD_ERROR; has1 = 1'b1; used = 1'b0;
                end
                else mode_next = csl_pkg::M_CHR_CLOSE;
            csl_pkg::M_CHR_CLOSE:
                if (!q_req.eos && c == 8'h27)
                begin
                    tk.kind = csl_pkg::KD_CHAR; has1 = 1'b1; mode_next = csl_pkg::M_IDLE;
                end
                else begin tk.kind = csl_pkg::KD_ERROR; has1 = 1'b1; used = 1'b0; end
            csl_pkg::M_OPER:
                if (q_req.eos)
                begin
                    tk.kind = csl_pkg::lone_kind(pend_reg); tk.length = 24'd1;
                    has1 = 1'b1; used = 1'b0;
                end
                else if (pend_reg == "/" && c == "/") mode_next = csl_pkg::M_LINE_SKIP;
                else if (pend_reg == "/" && c == "*") mode_next = csl_pkg::M_BLOCK;
                else if (pk[6])
                begin
                    tk.kind = pk[5:0]; tk.length = 24'd2; has1 = 1'b1;
                    mode_next = csl_pkg::M_IDLE;
                end
                else
                begin
                    tk.kind = csl_pkg::lone_kind(pend_reg); tk.length = 24'd1;
                    has1 = 1'b1; used = 1'b0;
                end
            csl_pkg::M_LINE_SKIP:
                if (q_req.eos) used = 1'b0;
                else if (c == 8'h0A) mode_next = csl_pkg::M_IDLE;
            csl_pkg::M_BLOCK:
                if (q_req.eos) used = 1'b0;
                else if (c == "*") mode_next = csl_pkg::M_BLOCK_STAR;
            csl_pkg::M_BLOCK_STAR:
                if (q_req.eos) used = 1'b0;
                else mode_next = (c == "/") ? csl_pkg::M_IDLE
                               : (c == "*") ? csl_pkg::M_BLOCK_STAR : csl_pkg::M_BLOCK;
            default: used = 1'b0;
        endcase
        t0 = tk;
        // second step: end of source or idle-start handling
        tk = '0;
        if (q_req.eos)
        begin
            tk.kind = csl_pkg::KD_EOF; tk.line = line_reg; tk.column = col_reg;
            tk.offset = pos_reg;
            mode_next = csl_pkg::M_IDLE; pos_next = '0; line_next = 20'd1; col_next = 16'd1;
            spos_next = '0; sline_next = 20'd1; scol_next = 16'd1; wcnt_next = '0;
            hex_next = '0; pend_next = '0;
            if (has1) begin t1 = tk; two_out = 1'b1; end
            else t0 = tk;
            n_out = 1'b1;
        end
        else
        begin
            if (!used)
            begin
                spos_next = pos_reg; sline_next = line_reg; scol_next = col_reg;
                mode_next = csl_pkg::M_IDLE;
                tk.line = line_reg; tk.column = col_reg; tk.offset = pos_reg; tk.length = 24'd1;
                if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin end
                else if (c == "#") mode_next = csl_pkg::M_LINE_SKIP;
                else if (csl_pkg::is_alpha(c) || c == 8'h5F)
                begin
                    mode_next = csl_pkg::M_IDENT; word_next[7:0] = c; wcnt_next = 5'd1;
                end
                else if (csl_pkg::is_digit(c))
                begin
                    mode_next = (c == "0") ? csl_pkg::M_ZERO : csl_pkg::M_DEC; hex_next = '0;
                end
                else if (c == 8'h22 || c == 8'h27)
                begin
                    mode_next = (c == 8'h22) ? csl_pkg::M_STR : csl_pkg::M_CHR_OPEN;
                    spos_next = pos_reg + 24'd1;
                end
                else if (csl_pkg::lone_kind(c) != csl_pkg::KD_ERROR)
                begin
                    mode_next = csl_pkg::M_OPER; pend_next = c;
                end
                else
                begin
                    tk.kind = csl_pkg::single_kind(c);
                    if (has1) begin t1 = tk; two_out = 1'b1; end
                    else t0 = tk;
                    has1 = 1'b1;
                end
            end
            n_out = has1;
            bpos = pos_reg + 24'd1; bline = line_reg; bcol = col_reg;
            if (c == 8'h0A)
            begin
                if (line_reg < csl_pkg::LINE_MAX) bline = line_reg + 20'd1;
                bcol = 16'd1;
            end
            else if (col_reg < csl_pkg::COL_MAX) bcol = col_reg + 16'd1;
            pos_next = bpos; line_next = bline; col_next = bcol;
        end
        if (two_out) t1.last = 1'b1; else t0.last = 1'b1;
    end

    always_ff @(posedge clk) begin
        if (q_pop && n_out)
        begin
            ob_reg[owp_reg] <= t0;
            if (two_out) ob_reg[~owp_reg] <= t1;
        end
        if (q_pop) word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            mode_reg <= csl_pkg::M_IDLE; pos_reg <= '0; line_reg <= 20'd1; col_reg <= 16'd1;
            spos_reg <= '0; sline_reg <= 20'd1; scol_reg <= 16'd1; wcnt_reg <= '0;
            hex_reg <= '0; pend_reg <= '0; ocnt_reg <= '0; orp_reg <= 1'b0; owp_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                mode_reg <= mode_next; pos_reg <= pos_next; line_reg <= line_next;
                col_reg <= col_next; spos_reg <= spos_next; sline_reg <= sline_next;
                scol_reg <= scol_next; wcnt_reg <= wcnt_next; hex_reg <= hex_next;
                pend_reg <= pend_next;
            end
            if (q_pop && n_out) owp_reg <= owp_reg ^ ~two_out;
            if (out_valid && out_ready) orp_reg <= ~orp_reg;
            ocnt_reg <= ocnt_reg + ((q_pop && n_out) ? (two_out ? 2'd2 : 2'd1) : 2'd0)
                        - ((out_valid && out_ready) ? 2'd1 : 2'd0);
        end
    end
endmodule
`default_nettype wire

>>> rtl/c_subset_lexer_core.sv
// Top level of the streaming C subset lexer.
// Usage:
//  Input channel: ch, end_of_source, with in_valid/in_ready. One request per
//  source byte; a request with end_of_source set closes the source.
//  Output channel: token fields with out_valid/out_ready; each token is one
//  request. last_of_run marks the last token caused by one input request.
//  A byte causes at most two tokens (a pending token closed, then a one-byte
//  token); end of source gives a flushed pending token, if any, and EOF.
//  Throughput: one byte per cycle while out_ready is high, set by the back
//  end mode update; a two-token byte stalls popping until the buffer drains.
//  Path: the byte that ends a token is registered in the input queue; the back
//  end then pops it and writes the token into an output buffer slot, which
//  raises out_valid.
//  Stall: when the receiver holds out_ready low the back end stops popping once
//  the two-slot output buffer holds a token, the input queue fills and in_ready
//  falls; nothing is lost.
//  Reset: asynchronous; mode idle, line and column one, position zero,
//  queues empty.
`default_nettype none
module c_subset_lexer_core #(
    parameter int KEYWORD_CHARS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        end_of_source,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       token_kind,
    output logic [19:0]      token_line,
    output logic [15:0]      token_column,
    output logic [23:0]      text_offset,
    output logic [23:0]      text_length,
    output logic [30:0]      number_value,
    output logic             last_of_run
);
    csl_pkg::byte_req_t in_req, q_req;
    csl_pkg::token_t tok;
    logic q_valid, q_pop;

    assign in_req.ch  = ch;
    assign in_req.eos = end_of_source;

    csl_front #(.DEPTH(2)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_req,
        .q_valid, .q_pop, .q_req
    );

    csl_back #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_req,
        .out_valid, .out_ready, .out_tok(tok)
    );

    assign token_kind   = tok.kind;
    assign token_line   = tok.line;
    assign token_column = tok.column;
    assign text_offset  = tok.offset;
    assign text_length  = tok.length;
    assign number_value = tok.value;
    assign last_of_run  = tok.last;
endmodule
`default_nettype wire

>>> rtl/csl_checker.sv
// Port-level checker for the lexer core, bound to the top level.
`default_nettype none
`include "c_subset_lexer_core_macros.svh"
module csl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [5:0]  token_kind,
    input wire logic [30:0] number_value,
    input wire logic [23:0] text_length,
    input wire logic        last_of_run
);
    `CSL_ASSERT_IMPL(a_eof_last, clk, rst_n, out_valid && token_kind == csl_pkg::KD_EOF, last_of_run && text_length == 24'd0, "EOF not last or nonzero length")
    `CSL_ASSERT_IMPL(a_value_num, clk, rst_n, out_valid && token_kind != csl_pkg::KD_NUMBER, number_value == 31'd0, "value on non-number")
    `CSL_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, token_kind <= 6'd58, "kind out of range")
    `CSL_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(token_kind), "stalled token changed")
endmodule
bind c_subset_lexer_core csl_checker u_checker (
    .clk, .rst_n, .out_valid, .out_ready, .token_kind, .number_value,
    .text_length, .last_of_run
);
`default_nettype wire
